[rtl/battery_gauge_monitor_core_macros.svh]
// assertion helpers shared by the rtl files
`ifndef BATTERY_GAUGE_MONITOR_CORE_MACROS_SVH
`define BATTERY_GAUGE_MONITOR_CORE_MACROS_SVH

// implication checked every clock edge outside reset
`define BGM_ASSERT_IMPL(label, clk_sig, rst_n_sig, ante, cons) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (ante) |-> (cons)) \
		else $error("bgm check failed");

// next-cycle implication
`define BGM_ASSERT_NEXT(label, clk_sig, rst_n_sig, ante, cons) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (ante) |=> (cons)) \
		else $error("bgm check failed");

`endif

[rtl/bgm_pkg.sv]
package bgm_pkg;

	localparam int SlopeWindowDef  = 6;
	localparam int LockoutCountDef = 3;
	localparam int SampleSecsDef   = 10;

	localparam int NumCfg = 6;

	typedef enum logic [2:0] {
		CFG_PRESENT_MIN = 3'd0,
		CFG_CRITICAL    = 3'd1,
		CFG_LOW         = 3'd2,
		CFG_RECOVER     = 3'd3,
		CFG_LOCKOUT     = 3'd4,
		CFG_FULL        = 3'd5
	} cfg_idx_t;

	localparam logic [1:0] CHG_DISCHARGING = 2'd0;
	localparam logic [1:0] CHG_CHARGING    = 2'd1;
	localparam logic [1:0] CHG_FULL        = 2'd2;

	localparam logic [1:0] ALR_OK   = 2'd0;
	localparam logic [1:0] ALR_LOW  = 2'd1;
	localparam logic [1:0] ALR_CRIT = 2'd2;

	localparam logic [1:0] EVT_NONE    = 2'd0;
	localparam logic [1:0] EVT_CRIT    = 2'd1;
	localparam logic [1:0] EVT_LOW     = 2'd2;
	localparam logic [1:0] EVT_RECOVER = 2'd3;

	localparam int FullStableNeed = 30;
	localparam int RisingUvS      = 8;
	localparam int ShowHyst       = 2;

	localparam int QueueDepth = 2;

	typedef struct packed {
		logic [15:0] mv;
		logic        usb;
		logic        present;
		logic [6:0]  raw_pct;
		logic        full_hit;
		logic        lock_low;
		logic        at_crit;
		logic        at_low;
		logic        at_recover;
		logic signed [21:0] slope;
	} bgm_item_t;

	typedef struct packed {
		logic [15:0] present_min_mv;
		logic [15:0] critical_mv;
		logic [15:0] low_mv;
		logic [15:0] recover_mv;
		logic [15:0] lock_thr_mv;
		logic [15:0] full_mv;
	} bgm_cfg_t;

	// piecewise-linear map, truncating
	function automatic logic [6:0] volt_to_pct(input logic [15:0] mv);
		logic [31:0] x;
		logic [31:0] d;
		logic [6:0] r;
		x = 32'd0;
		d = 32'd0;
		if (mv <= 16'd3000) begin
			r = 7'd0;
		end else if (mv >= 16'd4200) begin
			r = 7'd100;
		end else if (mv <= 16'd3400) begin
			// x*15/400 = 3x/80, reciprocal of 80 scaled by 2^18
			x = (32'(mv) - 32'd3000) * 32'd3;
			d = (x * 32'd3277) >> 18;
			r = 7'(d);
		end else if (mv <= 16'd4000) begin
			// x*75/600 is exactly x/8
			x = 32'(mv) - 32'd3400;
			d = x >> 3;
			r = 7'd15 + 7'(d);
		end else begin
			// x/20 through reciprocal scaled by 2^12
			x = 32'(mv) - 32'd4000;
			d = (x * 32'd205) >> 12;
			r = 7'd90 + 7'(d);
		end
		return r;
	endfunction

endpackage

[rtl/bgm_front.sv]
module bgm_front #(
	parameter int SLOPE_WINDOW   = bgm_pkg::SlopeWindowDef,
	parameter int SAMPLE_SECONDS = bgm_pkg::SampleSecsDef
) (
	input  logic              clk,
	input  logic              arst_n,
	input  bgm_pkg::bgm_cfg_t cfg,
	input  logic              in_take,
	input  logic [15:0]       cell_mv,
	input  logic              usb_present,
	output bgm_pkg::bgm_item_t item_s1,
	output logic              item_valid_s1,
	input  logic              item_take
);
	import bgm_pkg::*;

	localparam int HW = $clog2(SLOPE_WINDOW);
	localparam int Divisor = (SLOPE_WINDOW - 1) * SAMPLE_SECONDS;
	localparam int RecipShift = 27;
	localparam logic [36:0] SlopeRecip =
		37'(((64'd1 << RecipShift) * 64'd1000 + 64'(Divisor) - 64'd1) / 64'(Divisor));
	localparam logic signed [31:0] SlopeMax = 32'sd2097151;
	localparam logic signed [31:0] SlopeMin = -32'sd2097152;

	logic [15:0] ring_q [SLOPE_WINDOW];
	logic [HW-1:0] head_q;
	logic [HW:0] fill_q;
	logic signed [16:0] dmv_s1;
	logic dmv_ok_s1;
	bgm_item_t pre_s1;
	logic [15:0] dmv_mag;
	logic [52:0] slope_prod;
	logic [25:0] slope_mag;
	logic signed [31:0] quot;
	logic signed [31:0] slope_sat;
	logic [HW-1:0] head_nx;

	assign head_nx = (32'(head_q) == SLOPE_WINDOW - 1) ? '0 : head_q + 1'b1;

	always_ff @(posedge clk) begin
		if (in_take) ring_q[head_q] <= cell_mv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			fill_q <= '0;
			item_valid_s1 <= 1'b0;
		end else begin
			item_valid_s1 <= in_take || (item_valid_s1 && !item_take);
			if (in_take) begin
				head_q <= head_nx;
				if (32'(fill_q) < SLOPE_WINDOW) fill_q <= fill_q + 1'b1;
			end
		end
	end

	// once ring is full, the entry one past head is the oldest left after this write replaces head
	always_ff @(posedge clk) begin
		if (in_take) begin
			dmv_ok_s1 <= (32'(fill_q) == SLOPE_WINDOW);
			dmv_s1 <= $signed({1'b0, cell_mv}) - $signed({1'b0, ring_q[head_nx]});
			pre_s1.mv <= cell_mv;
			pre_s1.usb <= usb_present;
			pre_s1.present <= cell_mv >= cfg.present_min_mv;
			pre_s1.raw_pct <= volt_to_pct(cell_mv);
			pre_s1.full_hit <= cell_mv >= cfg.full_mv;
			pre_s1.lock_low <= cell_mv >= cfg.present_min_mv && cell_mv < cfg.lock_thr_mv;
			pre_s1.at_crit <= cell_mv <= cfg.critical_mv;
			pre_s1.at_low <= cell_mv <= cfg.low_mv;
			pre_s1.at_recover <= cell_mv >= cfg.recover_mv;
			pre_s1.slope <= '0;
		end
	end

	// |dmv|*1000/divisor by reciprocal multiply, exact for 16-bit magnitudes
	assign dmv_mag = dmv_s1[16] ? 16'(-dmv_s1) : dmv_s1[15:0];
	assign slope_prod = dmv_mag * SlopeRecip;
	assign slope_mag = slope_prod[RecipShift+25:RecipShift];
	assign quot = dmv_s1[16] ? -$signed({6'd0, slope_mag}) : $signed({6'd0, slope_mag});
	assign slope_sat = quot > SlopeMax ? SlopeMax : (quot < SlopeMin ? SlopeMin : quot);

	always_comb begin
		item_s1 = pre_s1;
		item_s1.slope = dmv_ok_s1 ? 22'(slope_sat) : '0;
	end

endmodule

[rtl/bgm_queue.sv]
module bgm_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  bgm_pkg::bgm_item_t push_word,
	output logic               full,
	input  logic               pop,
	output logic               not_empty,
	output bgm_pkg::bgm_item_t pop_word
);
	import bgm_pkg::*;

	localparam int AW = $clog2(QueueDepth);

	bgm_item_t mem_q [QueueDepth];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;

	assign full = 32'(cnt_q) == QueueDepth;
	assign not_empty = cnt_q != '0;
	assign pop_word = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (AW + 1)'(push) - (AW + 1)'(pop);
		end
	end

	`include "battery_gauge_monitor_core_macros.svh"
	`BGM_ASSERT_IMPL(a_no_overflow, clk, arst_n, full, !push || pop)
	`BGM_ASSERT_IMPL(a_no_underflow, clk, arst_n, !not_empty, !pop)
	`BGM_ASSERT_NEXT(a_push_seen, clk, arst_n, push && !pop, not_empty)

endmodule

[rtl/bgm_back.sv]
module bgm_back #(
	parameter int LOCKOUT_COUNT  = bgm_pkg::LockoutCountDef,
	parameter int SAMPLE_SECONDS = bgm_pkg::SampleSecsDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  bgm_pkg::bgm_item_t item,
	output logic               item_take,
	output logic               valid,
	input  logic               stall,
	output logic [6:0]         shown_pct,
	output logic               cell_present,
	output logic [1:0]         charge_mode,
	output logic               charge_changed,
	output logic               lockout_on,
	output logic               lockout_changed,
	output logic [1:0]         alert_level,
	output logic [1:0]         alert_event,
	output logic signed [21:0] slope_uv_per_s
);
	import bgm_pkg::*;

	localparam int SW = $clog2(LOCKOUT_COUNT + 1);

	logic [14:0] ewma_q;
	logic seeded_q;
	logic [6:0] disp_q, frozen_q;
	logic frozen_valid_q;
	logic [1:0] charge_q;
	logic [15:0] full_s_q;
	logic lock_q;
	logic [SW-1:0] streak_q;
	logic [1:0] alert_q;

	logic signed [16:0] diff;
	logic [14:0] ewma_nx;
	logic [6:0] sm, disp_nx;
	logic [16:0] tsum;
	logic [15:0] full_nx;
	logic [1:0] charge_nx, alert_nx, evt_nx;
	logic [SW-1:0] streak_nx;
	logic lock_nx;

	assign item_take = item_valid && (!valid || !stall);

	always_comb begin
		diff = $signed({2'b0, item.raw_pct, 8'd0}) - $signed({2'b0, ewma_q});
		// ((raw*256-acc)*32)/256 truncates toward zero: diff/8
		ewma_nx = seeded_q ? 15'(17'($signed({2'b0, ewma_q}) + 17'(diff / 17'sd8))) :
			{item.raw_pct, 8'd0};
		sm = ewma_nx[14:8] > 7'd100 ? 7'd100 : ewma_nx[14:8];
		disp_nx = disp_q;
		if (item.usb) begin
			disp_nx = frozen_valid_q ? frozen_q : item.raw_pct;
		end else if ((sm >= disp_q && sm - disp_q >= 7'(ShowHyst)) ||
				(disp_q > sm && disp_q - sm >= 7'(ShowHyst))) begin
			disp_nx = sm;
		end

		tsum = 17'(full_s_q) + 17'(SAMPLE_SECONDS);
		full_nx = '0;
		charge_nx = CHG_DISCHARGING;
		if (item.usb) begin
			if (item.full_hit) full_nx = tsum[16] ? 16'hFFFF : tsum[15:0];
			charge_nx = charge_q;
			if (32'(full_nx) >= FullStableNeed) charge_nx = CHG_FULL;
			else if (item.slope >= 22'(RisingUvS)) charge_nx = CHG_CHARGING;
			else if (charge_q == CHG_DISCHARGING) charge_nx = CHG_CHARGING;
		end

		streak_nx = '0;
		lock_nx = lock_q;
		if (!item.usb && item.lock_low) begin
			streak_nx = (32'(streak_q) < LOCKOUT_COUNT) ? streak_q + 1'b1 : streak_q;
			if (32'(streak_nx) >= LOCKOUT_COUNT) lock_nx = 1'b1;
		end
		if (item.usb) lock_nx = 1'b0;

		alert_nx = alert_q;
		evt_nx = EVT_NONE;
		if (!item.usb) begin
			if (!item.present) begin
				alert_nx = ALR_OK;
			end else begin
				if (item.at_crit) alert_nx = ALR_CRIT;
				else if (item.at_low) alert_nx = (alert_q == ALR_CRIT) ? ALR_CRIT : ALR_LOW;
				else if (item.at_recover) alert_nx = ALR_OK;
				if (alert_nx != alert_q) begin
					if (alert_nx == ALR_CRIT) evt_nx = EVT_CRIT;
					else if (alert_nx == ALR_LOW && alert_q == ALR_OK) evt_nx = EVT_LOW;
					else if (alert_nx == ALR_OK) evt_nx = EVT_RECOVER;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ewma_q <= '0;
			seeded_q <= 1'b0;
			disp_q <= '0;
			frozen_q <= '0;
			frozen_valid_q <= 1'b0;
			charge_q <= CHG_DISCHARGING;
			full_s_q <= '0;
			lock_q <= 1'b0;
			streak_q <= '0;
			alert_q <= ALR_OK;
			valid <= 1'b0;
		end else begin
			valid <= item_take || (valid && stall);
			if (item_take) begin
				disp_q <= disp_nx;
				if (!item.usb) begin
					ewma_q <= ewma_nx;
					seeded_q <= 1'b1;
					frozen_q <= disp_nx;
					frozen_valid_q <= 1'b1;
				end
				charge_q <= charge_nx;
				full_s_q <= full_nx;
				lock_q <= lock_nx;
				streak_q <= streak_nx;
				alert_q <= alert_nx;
			end
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (item_take) begin
			shown_pct <= item.present ? disp_nx : 7'd0;
			cell_present <= item.present;
			charge_mode <= charge_nx;
			charge_changed <= charge_nx != charge_q;
			lockout_on <= lock_nx;
			lockout_changed <= lock_nx != lock_q;
			alert_level <= alert_nx;
			alert_event <= evt_nx;
			slope_uv_per_s <= item.slope;
		end
	end

	`include "battery_gauge_monitor_core_macros.svh"
	`BGM_ASSERT_NEXT(a_usb_clears_lock, clk, arst_n, item_take && item.usb, !lock_q)
	`BGM_ASSERT_IMPL(a_charge_legal, clk, arst_n, 1'b1, charge_q != 2'd3 && alert_q != 2'd3)
	`BGM_ASSERT_NEXT(a_out_hold, clk, arst_n, valid && stall, valid && $stable(alert_level))

endmodule

[rtl/battery_gauge_monitor_core.sv]
// Battery gauge monitor: takes one cell voltage word (mV plus a USB-present flag) per cycle while
// in_stall is low and returns one status word per sample: displayed percent, cell presence,
// charge mode, lockout latch, alert level and event, and the window slope in uV/s. A front stage
// registers the threshold compares, the percent map and the slope-ring difference; a two-entry
// queue feeds the back stage that updates the smoothing, charge, lockout and alert state and
// holds the result in an output register. Sustained rate is one sample per cycle while out_stall
// is low, set by the back stage updating its state as it takes each word; an accepted word passes
// through the front register, the queue and the output register, and output stalls hold it back.
// Configuration should be written only while the block is idle.
module battery_gauge_monitor_core #(
	parameter int SLOPE_WINDOW   = bgm_pkg::SlopeWindowDef,
	parameter int LOCKOUT_COUNT  = bgm_pkg::LockoutCountDef,
	parameter int SAMPLE_SECONDS = bgm_pkg::SampleSecsDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [15:0]        cell_mv,
	input  logic               usb_present,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [6:0]         shown_pct,
	output logic               cell_present,
	output logic [1:0]         charge_mode,
	output logic               charge_changed,
	output logic               lockout_on,
	output logic               lockout_changed,
	output logic [1:0]         alert_level,
	output logic [1:0]         alert_event,
	output logic signed [21:0] slope_uv_per_s
);
	import bgm_pkg::*;

	bgm_cfg_t cfg_q;
	bgm_item_t item_s1, q_word;
	logic item_valid_s1, q_full, q_ne, back_take, push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.present_min_mv <= 16'd2500;
			cfg_q.critical_mv <= 16'd3200;
			cfg_q.low_mv <= 16'd3400;
			cfg_q.recover_mv <= 16'd3600;
			cfg_q.lock_thr_mv <= 16'd3100;
			cfg_q.full_mv <= 16'd4150;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PRESENT_MIN: cfg_q.present_min_mv <= cfg_data;
				CFG_CRITICAL:    cfg_q.critical_mv <= cfg_data;
				CFG_LOW:         cfg_q.low_mv <= cfg_data;
				CFG_RECOVER:     cfg_q.recover_mv <= cfg_data;
				CFG_LOCKOUT:     cfg_q.lock_thr_mv <= cfg_data;
				CFG_FULL:        cfg_q.full_mv <= cfg_data;
				default: ;
			endcase
		end
	end

	// front holds one word; it drains into the queue whenever there is room
	assign push = item_valid_s1 && !q_full;
	assign in_stall = item_valid_s1 && q_full;

	bgm_front #(.SLOPE_WINDOW(SLOPE_WINDOW), .SAMPLE_SECONDS(SAMPLE_SECONDS)) u_front (
		.clk, .arst_n, .cfg(cfg_q),
		.in_take(in_valid && !in_stall),
		.cell_mv, .usb_present,
		.item_s1, .item_valid_s1, .item_take(push)
	);

	bgm_queue u_queue (
		.clk, .arst_n, .push, .push_word(item_s1), .full(q_full),
		.pop(back_take), .not_empty(q_ne), .pop_word(q_word)
	);

	bgm_back #(.LOCKOUT_COUNT(LOCKOUT_COUNT), .SAMPLE_SECONDS(SAMPLE_SECONDS)) u_back (
		.clk, .arst_n, .item_valid(q_ne), .item(q_word), .item_take(back_take),
		.valid(out_valid), .stall(out_stall),
		.shown_pct, .cell_present, .charge_mode, .charge_changed,
		.lockout_on, .lockout_changed, .alert_level, .alert_event, .slope_uv_per_s
	);

endmodule
